// ----- design/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- design/biba_pkg.sv -----
`default_nettype none

package biba_pkg;

   localparam int INODE_SLOTS     = 1024;
   localparam int BLOCK_SLOTS     = 4096;
   localparam int BLOCKS_PER_FILE = 6;

   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam int INODE_WORDS = (INODE_SLOTS + WORD_W - 1) / WORD_W;
   localparam int BLOCK_WORDS = (BLOCK_SLOTS + WORD_W - 1) / WORD_W;
   localparam int INO_ADDR_W  = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
   localparam int BLK_ADDR_W  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
   localparam int INO_IDX_W   = INO_ADDR_W + BIT_W;
   localparam int BLK_IDX_W   = BLK_ADDR_W + BIT_W;
   localparam int INO_LIM_W   = INO_IDX_W + 1;
   localparam int BLK_LIM_W   = BLK_IDX_W + 1;
   localparam int SCAN_HI_W   = ((INO_ADDR_W > BLK_ADDR_W) ? INO_ADDR_W : BLK_ADDR_W) + 1;
   localparam int BLK_CNT_W   = $clog2(BLOCKS_PER_FILE + 1);

   // fixed field widths
   localparam int ACTION_W      = 1;
   localparam int TARGET_W      = 10;
   localparam int KIND_W        = 2;
   localparam int INDEX_W       = 12;
   localparam int STATUS_W      = 2;
   localparam int INODE_COUNT_W = 11;
   localparam int BLOCK_COUNT_W = 13;
   localparam int PROT_W        = 10;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 13;

   localparam int INODE_COUNT_RST = 1024;
   localparam int BLOCK_COUNT_RST = 4096;
   localparam int INO_LIM_RST = (INODE_COUNT_RST > INODE_SLOTS) ? INODE_SLOTS : INODE_COUNT_RST;
   localparam int BLK_LIM_RST = (BLOCK_COUNT_RST > BLOCK_SLOTS) ? BLOCK_SLOTS : BLOCK_COUNT_RST;

   localparam logic ACT_ALLOC   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_INODE  = 2'd0,
      KIND_BLOCK  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_INVALID  = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INODE_COUNT     = 2'd0,
      CSR_BLOCK_COUNT     = 2'd1,
      CSR_PROTECTED_INODE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REL_WR,
      S_INO_SCAN,
      S_BLK_SCAN,
      S_COMMIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [INO_LIM_W-1:0] ino_lim;
      logic [BLK_LIM_W-1:0] blk_lim;
      logic [PROT_W-1:0]    prot_inode;
   } cfg_type;

   typedef struct packed {
      logic                  rd_en;
      logic [INO_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [INO_ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } ino_ram_req_type;

   typedef struct packed {
      logic                  rd_en;
      logic [BLK_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [BLK_ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]     wr_data;
   } blk_ram_req_type;

   // bits of a map word that lie below the limit
   function automatic logic [WORD_W-1:0] word_mask(input logic [SCAN_HI_W-1:0] word,
                                                   input logic [SCAN_HI_W-1:0] lim_hi,
                                                   input logic [BIT_W-1:0]     lim_lo);
      logic [WORD_W-1:0] mask;
      if (word < lim_hi) begin
         mask = '1;
      end else if (word == lim_hi) begin
         mask = ~({WORD_W{1'b1}} << lim_lo);
      end else begin
         mask = '0;
      end
      return mask;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ----- design/biba_req_if.sv -----
`default_nettype none

interface biba_req_if;
   logic                          valid;
   logic                          ready;
   logic [biba_pkg::ACTION_W-1:0] action;
   logic [biba_pkg::TARGET_W-1:0] target_inode;

   modport source (output valid, output action, output target_inode, input ready);
   modport sink   (input valid, input action, input target_inode, output ready);
endinterface

`default_nettype wire

// ----- design/biba_rsp_if.sv -----
`default_nettype none

interface biba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [biba_pkg::KIND_W-1:0]   kind;
   logic [biba_pkg::INDEX_W-1:0]  index;
   logic [biba_pkg::STATUS_W-1:0] status;
   logic                          last;

   modport source (output valid, output kind, output index, output status, output last,
                   input ready);
   modport sink   (input valid, input kind, input index, input status, input last,
                   output ready);
endinterface

`default_nettype wire

// ----- design/biba_map_ram.sv -----
`default_nettype none

module biba_map_ram #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // a word never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/biba_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"

module biba_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire biba_pkg::cfg_type                 cfg,
   biba_req_if.sink                               req_ch,
   biba_rsp_if.source                             rsp_ch,
   output biba_pkg::ino_ram_req_type              ino_req,
   input  wire logic [biba_pkg::WORD_W-1:0]       ino_rdata,
   output biba_pkg::blk_ram_req_type              blk_req,
   input  wire logic [biba_pkg::WORD_W-1:0]       blk_rdata
);

   localparam int BPF = biba_pkg::BLOCKS_PER_FILE;

   biba_pkg::state_type state_ff, state_in;

   logic [biba_pkg::INO_ADDR_W-1:0] ino_word_ff, ino_word_in;
   logic [biba_pkg::INO_IDX_W-1:0]  ino_hit_ff, ino_hit_in;
   logic [biba_pkg::WORD_W-1:0]     ino_data_ff, ino_data_in;

   logic [biba_pkg::BLK_ADDR_W:0]   bptr_ff, bptr_in;
   logic [biba_pkg::BLK_ADDR_W-1:0] bword_ff, bword_in;
   logic                            bdvalid_ff, bdvalid_in;
   logic [biba_pkg::WORD_W-1:0]     work_ff, work_in;
   logic [biba_pkg::BLK_ADDR_W-1:0] work_word_ff, work_word_in;
   logic [biba_pkg::BLK_CNT_W-1:0]  seq_ff, seq_in;
   logic [biba_pkg::BLK_IDX_W-1:0]  blk_q_ff [BPF];
   logic [biba_pkg::BLK_IDX_W-1:0]  blk_q_in [BPF];

   logic [biba_pkg::BLK_IDX_W-1:0]  pend_blk_ff, pend_blk_in;
   logic                            fwd_vld_ff, fwd_vld_in;
   logic [biba_pkg::BLK_ADDR_W-1:0] fwd_word_ff, fwd_word_in;
   logic [biba_pkg::WORD_W-1:0]     fwd_data_ff, fwd_data_in;

   logic                   single_ff, single_in;
   biba_pkg::status_type   single_st_ff, single_st_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   biba_pkg::kind_type                rsp_kind_ff, rsp_kind_in;
   logic [biba_pkg::INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   biba_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              req_fire;
   logic                              lim_zero;
   logic                              is_protected;
   logic                              tgt_in_range;
   logic [biba_pkg::INO_IDX_W-1:0]    tgt_idx;

   logic [biba_pkg::INO_LIM_W-1:0]    ino_lim_m1;
   logic [biba_pkg::INO_ADDR_W:0]     ino_last_w;
   logic [biba_pkg::INO_ADDR_W:0]     ino_word_ext;
   logic [biba_pkg::WORD_W-1:0]       ino_free;
   logic                              ino_found;
   logic                              ino_at_last;

   logic [biba_pkg::BLK_LIM_W-1:0]    blk_lim_m1;
   logic [biba_pkg::BLK_ADDR_W:0]     blk_last_w;
   logic [biba_pkg::WORD_W-1:0]       blk_free;
   logic                              use_work;
   logic [biba_pkg::WORD_W-1:0]       sel;
   logic [biba_pkg::WORD_W-1:0]       sel_lsb;
   logic [biba_pkg::BLK_ADDR_W-1:0]   sel_word;
   logic [biba_pkg::BLK_IDX_W-1:0]    rec_blk;
   logic                              consume;
   logic                              bmore;
   logic                              rec_en;
   logic                              gather_done;
   logic                              blk_fail;

   logic [biba_pkg::BLK_ADDR_W-1:0]   cm_word;
   logic [biba_pkg::WORD_W-1:0]       cm_base;
   logic [biba_pkg::WORD_W-1:0]       cm_data;
   logic                              commit_done;

   logic                              rsp_load;
   logic                              beat_last;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign lim_zero     = (cfg.ino_lim == '0) || (cfg.blk_lim == '0);
   assign is_protected = (req_ch.target_inode == cfg.prot_inode);
   assign tgt_in_range = 32'(req_ch.target_inode) < biba_pkg::INODE_SLOTS;
   assign tgt_idx      = biba_pkg::INO_IDX_W'(req_ch.target_inode);

   // inode scan: one word a cycle, lowest free bit below the limit
   assign ino_lim_m1   = cfg.ino_lim - biba_pkg::INO_LIM_W'(1);
   assign ino_last_w   = ino_lim_m1[biba_pkg::INO_LIM_W-1:biba_pkg::BIT_W];
   assign ino_word_ext = {1'b0, ino_word_ff};
   assign ino_free     = ~ino_rdata & biba_pkg::word_mask(
                            biba_pkg::SCAN_HI_W'(ino_word_ff),
                            biba_pkg::SCAN_HI_W'(cfg.ino_lim[biba_pkg::INO_LIM_W-1:biba_pkg::BIT_W]),
                            cfg.ino_lim[biba_pkg::BIT_W-1:0]);
   assign ino_found    = (ino_free != '0);
   assign ino_at_last  = (ino_word_ext == ino_last_w);

   // block scan: a word is parked in work_ff while its free bits are picked one a cycle
   assign blk_lim_m1  = cfg.blk_lim - biba_pkg::BLK_LIM_W'(1);
   assign blk_last_w  = blk_lim_m1[biba_pkg::BLK_LIM_W-1:biba_pkg::BIT_W];
   assign blk_free    = ~blk_rdata & biba_pkg::word_mask(
                           biba_pkg::SCAN_HI_W'(bword_ff),
                           biba_pkg::SCAN_HI_W'(cfg.blk_lim[biba_pkg::BLK_LIM_W-1:biba_pkg::BIT_W]),
                           cfg.blk_lim[biba_pkg::BIT_W-1:0]);
   assign use_work    = (work_ff != '0);
   assign sel         = use_work ? work_ff : (bdvalid_ff ? blk_free : '0);
   assign sel_lsb     = sel & (~sel + biba_pkg::WORD_W'(1));
   assign sel_word    = use_work ? work_word_ff : bword_ff;
   assign rec_blk     = {sel_word, biba_pkg::lowest_bit(sel)};
   assign consume     = !use_work && bdvalid_ff;
   assign bmore       = (bptr_ff <= blk_last_w);
   assign rec_en      = (state_ff == biba_pkg::S_BLK_SCAN) && (sel != '0);
   assign gather_done = rec_en && (seq_ff == biba_pkg::BLK_CNT_W'(BPF - 1));
   assign blk_fail    = (state_ff == biba_pkg::S_BLK_SCAN) && (sel == '0) && !bdvalid_ff;

   // commit: read next block word while writing the previous one, forward on same word
   assign cm_word     = pend_blk_ff[biba_pkg::BLK_IDX_W-1:biba_pkg::BIT_W];
   assign cm_base     = (fwd_vld_ff && (fwd_word_ff == cm_word)) ? fwd_data_ff : blk_rdata;
   assign cm_data     = cm_base |
                        (biba_pkg::WORD_W'(1) << pend_blk_ff[biba_pkg::BIT_W-1:0]);
   assign commit_done = (state_ff == biba_pkg::S_COMMIT) &&
                        (seq_ff == biba_pkg::BLK_CNT_W'(BPF));

   assign rsp_load  = (state_ff == biba_pkg::S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign beat_last = single_ff || (seq_ff == biba_pkg::BLK_CNT_W'(BPF));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         biba_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_ch.action == biba_pkg::ACT_RELEASE) begin
                  if (!is_protected && tgt_in_range) begin
                     state_in = biba_pkg::S_REL_WR;
                  end else begin
                     state_in = biba_pkg::S_EMIT;
                  end
               end else if (lim_zero) begin
                  state_in = biba_pkg::S_EMIT;
               end else begin
                  state_in = biba_pkg::S_INO_SCAN;
               end
            end
         end
         biba_pkg::S_REL_WR: begin
            state_in = biba_pkg::S_EMIT;
         end
         biba_pkg::S_INO_SCAN: begin
            if (ino_found) begin
               state_in = biba_pkg::S_BLK_SCAN;
            end else if (ino_at_last) begin
               state_in = biba_pkg::S_EMIT;
            end
         end
         biba_pkg::S_BLK_SCAN: begin
            if (gather_done) begin
               state_in = biba_pkg::S_COMMIT;
            end else if (blk_fail) begin
               state_in = biba_pkg::S_EMIT;
            end
         end
         biba_pkg::S_COMMIT: begin
            if (commit_done) begin
               state_in = biba_pkg::S_EMIT;
            end
         end
         biba_pkg::S_EMIT: begin
            if (rsp_load && beat_last) begin
               state_in = biba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = biba_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ino_req       = '0;
      blk_req       = '0;
      ino_word_in   = ino_word_ff;
      ino_hit_in    = ino_hit_ff;
      ino_data_in   = ino_data_ff;
      bptr_in       = bptr_ff;
      bword_in      = bword_ff;
      bdvalid_in    = bdvalid_ff;
      work_in       = work_ff;
      work_word_in  = work_word_ff;
      seq_in        = seq_ff;
      blk_q_in      = blk_q_ff;
      pend_blk_in   = pend_blk_ff;
      fwd_vld_in    = fwd_vld_ff;
      fwd_word_in   = fwd_word_ff;
      fwd_data_in   = fwd_data_ff;
      single_in     = single_ff;
      single_st_in  = single_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         biba_pkg::S_IDLE: begin
            if (req_fire) begin
               seq_in = '0;
               if (req_ch.action == biba_pkg::ACT_RELEASE) begin
                  single_in    = 1'b1;
                  single_st_in = is_protected ? biba_pkg::ST_INVALID : biba_pkg::ST_OK;
                  ino_hit_in   = tgt_idx;
                  if (!is_protected && tgt_in_range) begin
                     ino_req.rd_en   = 1'b1;
                     ino_req.rd_addr = tgt_idx[biba_pkg::INO_IDX_W-1:biba_pkg::BIT_W];
                  end
               end else if (lim_zero) begin
                  single_in    = 1'b1;
                  single_st_in = biba_pkg::ST_NO_SPACE;
               end else begin
                  single_in       = 1'b0;
                  ino_req.rd_en   = 1'b1;
                  ino_req.rd_addr = '0;
                  ino_word_in     = '0;
               end
            end
         end
         biba_pkg::S_REL_WR: begin
            ino_req.wr_en   = 1'b1;
            ino_req.wr_addr = ino_hit_ff[biba_pkg::INO_IDX_W-1:biba_pkg::BIT_W];
            ino_req.wr_data = ino_rdata &
                              ~(biba_pkg::WORD_W'(1) << ino_hit_ff[biba_pkg::BIT_W-1:0]);
         end
         biba_pkg::S_INO_SCAN: begin
            if (ino_found) begin
               ino_hit_in      = {ino_word_ff, biba_pkg::lowest_bit(ino_free)};
               ino_data_in     = ino_rdata;
               blk_req.rd_en   = 1'b1;
               blk_req.rd_addr = '0;
               bptr_in         = (biba_pkg::BLK_ADDR_W + 1)'(1);
               bword_in        = '0;
               bdvalid_in      = 1'b1;
               work_in         = '0;
               seq_in          = '0;
            end else if (ino_at_last) begin
               single_in    = 1'b1;
               single_st_in = biba_pkg::ST_NO_SPACE;
            end else begin
               ino_req.rd_en   = 1'b1;
               ino_req.rd_addr = ino_word_ff + biba_pkg::INO_ADDR_W'(1);
               ino_word_in     = ino_word_ff + biba_pkg::INO_ADDR_W'(1);
            end
         end
         biba_pkg::S_BLK_SCAN: begin
            if (consume) begin
               if (bmore) begin
                  blk_req.rd_en   = 1'b1;
                  blk_req.rd_addr = bptr_ff[biba_pkg::BLK_ADDR_W-1:0];
                  bword_in        = bptr_ff[biba_pkg::BLK_ADDR_W-1:0];
                  bptr_in         = bptr_ff + (biba_pkg::BLK_ADDR_W + 1)'(1);
               end else begin
                  bdvalid_in = 1'b0;
               end
            end
            if (rec_en) begin
               work_in      = sel & ~sel_lsb;
               work_word_in = sel_word;
               for (int i = 0; i < BPF - 1; i++) begin
                  blk_q_in[i] = blk_q_ff[i+1];
               end
               blk_q_in[BPF-1] = rec_blk;
               seq_in          = seq_ff + biba_pkg::BLK_CNT_W'(1);
               if (gather_done) begin
                  seq_in     = '0;
                  fwd_vld_in = 1'b0;
               end
            end else if (blk_fail) begin
               single_in    = 1'b1;
               single_st_in = biba_pkg::ST_NO_SPACE;
            end
         end
         biba_pkg::S_COMMIT: begin
            if (seq_ff == '0) begin
               ino_req.wr_en   = 1'b1;
               ino_req.wr_addr = ino_hit_ff[biba_pkg::INO_IDX_W-1:biba_pkg::BIT_W];
               ino_req.wr_data = ino_data_ff |
                                 (biba_pkg::WORD_W'(1) << ino_hit_ff[biba_pkg::BIT_W-1:0]);
            end else begin
               blk_req.wr_en   = 1'b1;
               blk_req.wr_addr = cm_word;
               blk_req.wr_data = cm_data;
               fwd_vld_in      = 1'b1;
               fwd_word_in     = cm_word;
               fwd_data_in     = cm_data;
            end
            if (seq_ff < biba_pkg::BLK_CNT_W'(BPF)) begin
               // rotate so the queue is back in order once every block has passed
               blk_req.rd_en   = 1'b1;
               blk_req.rd_addr = blk_q_ff[0][biba_pkg::BLK_IDX_W-1:biba_pkg::BIT_W];
               pend_blk_in     = blk_q_ff[0];
               for (int i = 0; i < BPF - 1; i++) begin
                  blk_q_in[i] = blk_q_ff[i+1];
               end
               blk_q_in[BPF-1] = blk_q_ff[0];
            end
            seq_in = commit_done ? '0 : seq_ff + biba_pkg::BLK_CNT_W'(1);
         end
         biba_pkg::S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               seq_in       = seq_ff + biba_pkg::BLK_CNT_W'(1);
               if (single_ff) begin
                  rsp_kind_in   = biba_pkg::KIND_STATUS;
                  rsp_index_in  = '0;
                  rsp_status_in = single_st_ff;
                  rsp_last_in   = 1'b1;
               end else if (seq_ff == '0) begin
                  rsp_kind_in   = biba_pkg::KIND_INODE;
                  rsp_index_in  = biba_pkg::INDEX_W'(ino_hit_ff);
                  rsp_status_in = biba_pkg::ST_OK;
                  rsp_last_in   = 1'b0;
               end else begin
                  rsp_kind_in   = biba_pkg::KIND_BLOCK;
                  rsp_index_in  = biba_pkg::INDEX_W'(blk_q_ff[0]);
                  rsp_status_in = biba_pkg::ST_OK;
                  rsp_last_in   = beat_last;
                  for (int i = 0; i < BPF - 1; i++) begin
                     blk_q_in[i] = blk_q_ff[i+1];
                  end
                  blk_q_in[BPF-1] = blk_q_ff[0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= biba_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         bdvalid_ff   <= 1'b0;
         fwd_vld_ff   <= 1'b0;
         seq_ff       <= '0;
         single_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bdvalid_ff   <= bdvalid_in;
         fwd_vld_ff   <= fwd_vld_in;
         seq_ff       <= seq_in;
         single_ff    <= single_in;
      end
   end

   always_ff @(posedge clock) begin
      ino_word_ff   <= ino_word_in;
      ino_hit_ff    <= ino_hit_in;
      ino_data_ff   <= ino_data_in;
      bptr_ff       <= bptr_in;
      bword_ff      <= bword_in;
      work_ff       <= work_in;
      work_word_ff  <= work_word_in;
      blk_q_ff      <= blk_q_in;
      pend_blk_ff   <= pend_blk_in;
      fwd_word_ff   <= fwd_word_in;
      fwd_data_ff   <= fwd_data_in;
      single_st_ff  <= single_st_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ch.ready  = (state_ff == biba_pkg::S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.kind   = rsp_kind_ff;
   assign rsp_ch.index  = rsp_index_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.last   = rsp_last_ff;

   logic [biba_pkg::INO_ADDR_W:0] ino_rd_ext;
   assign ino_rd_ext = {1'b0, ino_req.rd_addr};

   `ASSERT_CLK(a_blk_ascending, clock, reset, (rec_en && (seq_ff != '0)) |-> (rec_blk > blk_q_ff[BPF-1]), "block picks not ascending")
   `ASSERT_CLK(a_blk_wr_commit, clock, reset, blk_req.wr_en |-> (state_ff == biba_pkg::S_COMMIT), "block map written outside commit")
   `ASSERT_CLK(a_ino_wr_place, clock, reset, ino_req.wr_en |-> ((state_ff == biba_pkg::S_REL_WR) || ((state_ff == biba_pkg::S_COMMIT) && (seq_ff == '0))), "inode map written at wrong time")
   `ASSERT_CLK(a_ino_scan_bound, clock, reset, (ino_req.rd_en && (state_ff == biba_pkg::S_INO_SCAN)) |-> (ino_rd_ext <= ino_last_w), "inode scan past limit")

endmodule

`default_nettype wire

// ----- design/bitmap_inode_block_allocator_core.sv -----
`default_nettype none

// First-fit inode and data-block allocator. Both used-bit maps sit in single-port-read
// memories of 32-bit words, read one word per cycle; they read as all free after reset
// with no clearing pass. A release reads the inode word, writes it back with the bit
// cleared and then gives its status beat; a refused release goes straight to its status
// beat. An allocate scans up to ceil(inode_count/32) inode words until a free inode
// shows, then up to ceil(block_count/32) block words, picking each further block from a
// word already fetched (at most 5) before the next word is read, then commits by
// read-modify-write of the inode word and each block word and sends 7 result beats. A
// request is taken only when the previous one has handed its last beat to the output
// register. A no-space answer leaves both maps unchanged.
module bitmap_inode_block_allocator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   biba_req_if.sink                               req_ch,
   biba_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [biba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [biba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   biba_pkg::cfg_type          cfg_ff, cfg_in;
   biba_pkg::ino_ram_req_type  ino_req;
   biba_pkg::blk_ram_req_type  blk_req;
   logic [biba_pkg::WORD_W-1:0] ino_rdata;
   logic [biba_pkg::WORD_W-1:0] blk_rdata;
   logic [biba_pkg::INODE_COUNT_W-1:0] ino_cnt_wr;
   logic [biba_pkg::BLOCK_COUNT_W-1:0] blk_cnt_wr;

   assign ino_cnt_wr = csr_wdata[biba_pkg::INODE_COUNT_W-1:0];
   assign blk_cnt_wr = csr_wdata[biba_pkg::BLOCK_COUNT_W-1:0];

   // limits are held already clamped to the map size
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            biba_pkg::CSR_INODE_COUNT: begin
               cfg_in.ino_lim = (32'(ino_cnt_wr) > biba_pkg::INODE_SLOTS) ?
                                biba_pkg::INO_LIM_W'(biba_pkg::INODE_SLOTS) :
                                biba_pkg::INO_LIM_W'(ino_cnt_wr);
            end
            biba_pkg::CSR_BLOCK_COUNT: begin
               cfg_in.blk_lim = (32'(blk_cnt_wr) > biba_pkg::BLOCK_SLOTS) ?
                                biba_pkg::BLK_LIM_W'(biba_pkg::BLOCK_SLOTS) :
                                biba_pkg::BLK_LIM_W'(blk_cnt_wr);
            end
            biba_pkg::CSR_PROTECTED_INODE: begin
               cfg_in.prot_inode = csr_wdata[biba_pkg::PROT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ino_lim    <= biba_pkg::INO_LIM_W'(biba_pkg::INO_LIM_RST);
         cfg_ff.blk_lim    <= biba_pkg::BLK_LIM_W'(biba_pkg::BLK_LIM_RST);
         cfg_ff.prot_inode <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   biba_map_ram #(
      .DEPTH  (biba_pkg::INODE_WORDS),
      .DATA_W (biba_pkg::WORD_W)
   ) u_ino_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ino_req.rd_en),
      .rd_addr (ino_req.rd_addr),
      .rd_data (ino_rdata),
      .wr_en   (ino_req.wr_en),
      .wr_addr (ino_req.wr_addr),
      .wr_data (ino_req.wr_data)
   );

   biba_map_ram #(
      .DEPTH  (biba_pkg::BLOCK_WORDS),
      .DATA_W (biba_pkg::WORD_W)
   ) u_blk_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (blk_req.rd_en),
      .rd_addr (blk_req.rd_addr),
      .rd_data (blk_rdata),
      .wr_en   (blk_req.wr_en),
      .wr_addr (blk_req.wr_addr),
      .wr_data (blk_req.wr_data)
   );

   biba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .ino_req   (ino_req),
      .ino_rdata (ino_rdata),
      .blk_req   (blk_req),
      .blk_rdata (blk_rdata)
   );

endmodule

`default_nettype wire

// ----- dv/bitmap_inode_block_allocator_checker.sv -----
module bitmap_inode_block_allocator_checker
   import biba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   biba_req_if                        req_ch,
   biba_rsp_if                        rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         beats_due
);

   typedef struct packed {
      kind_type             kind;
      logic [INDEX_W-1:0]   index;
      status_type           status;
      logic                 last;
   } alloc_beat_type;

   logic [INODE_SLOTS-1:0]   inode_taken;
   logic [BLOCK_SLOTS-1:0]   block_taken;
   logic [INODE_COUNT_W-1:0] inode_limit;
   logic [BLOCK_COUNT_W-1:0] block_limit;
   logic [PROT_W-1:0]        guard_inode;
   alloc_beat_type           beats_ahead[$];
   int                       mismatches = 0;
   int                       beats_waiting = 0;

   assign fail_count = mismatches;
   assign beats_due  = beats_waiting;

   function automatic alloc_beat_type make_beat(input kind_type k, input int unsigned idx,
                                                input status_type s, input logic l);
      alloc_beat_type b;
      b.kind   = k;
      b.index  = INDEX_W'(idx);
      b.status = s;
      b.last   = l;
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] allocator mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic predict_release(input logic [TARGET_W-1:0] tgt);
      if (tgt == guard_inode) begin
         beats_ahead.push_back(make_beat(KIND_STATUS, 0, ST_INVALID, 1'b1));
      end else begin
         if (int'(tgt) < INODE_SLOTS) begin
            inode_taken[tgt] = 1'b0;
         end
         beats_ahead.push_back(make_beat(KIND_STATUS, 0, ST_OK, 1'b1));
      end
   endtask

   task automatic predict_allocate();
      int unsigned ilim;
      int unsigned blim;
      int unsigned ino;
      int unsigned nblk;
      int unsigned picked[BLOCKS_PER_FILE];
      bit          found;
      ilim  = (inode_limit > INODE_SLOTS) ? INODE_SLOTS : inode_limit;
      blim  = (block_limit > BLOCK_SLOTS) ? BLOCK_SLOTS : block_limit;
      found = 1'b0;
      ino   = 0;
      nblk  = 0;
      for (int unsigned i = 0; i < ilim && !found; i++) begin
         if (!inode_taken[i]) begin
            ino   = i;
            found = 1'b1;
         end
      end
      for (int unsigned i = 0; i < blim && nblk < BLOCKS_PER_FILE; i++) begin
         if (!block_taken[i]) begin
            picked[nblk] = i;
            nblk++;
         end
      end
      // no space leaves both maps untouched
      if (!found || nblk < BLOCKS_PER_FILE) begin
         beats_ahead.push_back(make_beat(KIND_STATUS, 0, ST_NO_SPACE, 1'b1));
      end else begin
         inode_taken[ino] = 1'b1;
         beats_ahead.push_back(make_beat(KIND_INODE, ino, ST_OK, 1'b0));
         for (int k = 0; k < BLOCKS_PER_FILE; k++) begin
            block_taken[picked[k]] = 1'b1;
            beats_ahead.push_back(make_beat(KIND_BLOCK, picked[k], ST_OK,
                                            k == BLOCKS_PER_FILE - 1));
         end
      end
   endtask

   always @(posedge clock) begin
      alloc_beat_type want;
      if (reset) begin
         inode_taken = '0;
         block_taken = '0;
         inode_limit = INODE_COUNT_W'(INODE_COUNT_RST);
         block_limit = BLOCK_COUNT_W'(BLOCK_COUNT_RST);
         guard_inode = '0;
         beats_ahead.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INODE_COUNT:     inode_limit = csr_wdata[INODE_COUNT_W-1:0];
               CSR_BLOCK_COUNT:     block_limit = csr_wdata[BLOCK_COUNT_W-1:0];
               CSR_PROTECTED_INODE: guard_inode = csr_wdata[PROT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (beats_ahead.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind %0d index %0d status %0d last %0d",
                                         rsp_ch.kind, rsp_ch.index, rsp_ch.status,
                                         rsp_ch.last));
            end else begin
               want = beats_ahead.pop_front();
               if ({rsp_ch.kind, rsp_ch.index, rsp_ch.status, rsp_ch.last} !== want) begin
                  report_mismatch($sformatf(
                     "got kind %0d index %0d status %0d last %0d, want %0d %0d %0d %0d",
                     rsp_ch.kind, rsp_ch.index, rsp_ch.status, rsp_ch.last,
                     want.kind, want.index, want.status, want.last));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.action == ACT_RELEASE) begin
               predict_release(req_ch.target_inode);
            end else begin
               predict_allocate();
            end
         end
      end
      beats_waiting <= beats_ahead.size();
   end

endmodule

// ----- dv/bitmap_inode_block_allocator_core_tb.sv -----
module bitmap_inode_block_allocator_core_tb;
   import biba_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES = 200;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 48;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_ready = 1'b1;
   bit                    quiet = 1'b0;
   bit                    calm = 1'b0;
   int unsigned           stall_left = 0;
   int unsigned           window_left = 0;
   int unsigned           cur_icount = INODE_COUNT_RST;
   int unsigned           cur_prot = 0;
   int                    mismatch_total;
   int                    beats_due;
   int                    drain;

   biba_req_if req_ch ();
   biba_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_ready;

   bitmap_inode_block_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bitmap_inode_block_allocator_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (mismatch_total),
      .beats_due  (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver stalls in bursts, with quiet windows where it never stalls
   always @(posedge clock) begin
      if (window_left == 0) begin
         quiet       <= ($urandom_range(0, 3) == 0);
         window_left <= $urandom_range(40, 160);
      end else begin
         window_left <= window_left - 1;
      end
      if (calm || quiet) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) begin
            rsp_ready <= 1'b1;
         end
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(1, 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic act, input logic [TARGET_W-1:0] tgt);
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.target_inode <= tgt;
      do @(posedge clock); while (!req_ch.ready);
      if (!calm && !quiet && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
   endtask

   task automatic load_settings(input int unsigned icount, input int unsigned bcount,
                                input int unsigned prot, input bit poke_unmapped);
      csr_we    <= 1'b1;
      csr_index <= CSR_INODE_COUNT;
      csr_wdata <= CSR_DATA_W'(icount);
      @(posedge clock);
      csr_index <= CSR_BLOCK_COUNT;
      csr_wdata <= CSR_DATA_W'(bcount);
      @(posedge clock);
      csr_index <= CSR_PROTECTED_INODE;
      csr_wdata <= CSR_DATA_W'(prot);
      @(posedge clock);
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_wdata <= '1;
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      cur_icount = icount;
      cur_prot   = prot;
   endtask

   task automatic random_phase(input int n);
      logic                act;
      logic [TARGET_W-1:0] tgt;
      int unsigned         roll;
      int unsigned         hint;
      hint = (cur_icount + 3 > 1023) ? 1023 : cur_icount + 3;
      for (int i = 0; i < n; i++) begin
         act  = ($urandom_range(0, 99) < 55) ? ACT_ALLOC : ACT_RELEASE;
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            tgt = TARGET_W'(cur_prot);
         end else if (roll < 70) begin
            tgt = TARGET_W'($urandom_range(0, hint));
         end else begin
            tgt = TARGET_W'($urandom_range(0, 1023));
         end
         send_request(act, tgt);
      end
   endtask

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACT_ALLOC;
      req_ch.target_inode <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_INODE_COUNT;
      csr_wdata           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits: refused root, release of a used and a free inode, top target
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_ALLOC, 10'h3ff);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_RELEASE, 10'd0);
      send_request(ACT_RELEASE, 10'd1);
      send_request(ACT_RELEASE, 10'd1);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_RELEASE, 10'h3ff);

      // zero inode count means no space; unmapped register write is dropped
      wait_idle();
      load_settings(0, 4096, 0, 1'b1);
      send_request(ACT_ALLOC, 10'd0);

      // inode count above the map, zero block count, root at the top
      wait_idle();
      load_settings(2047, 0, 1023, 1'b0);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_RELEASE, 10'h3ff);
      send_request(ACT_RELEASE, 10'd0);

      // tiny inode range: fill it, release above the count, reuse
      wait_idle();
      load_settings(3, 8191, 512, 1'b0);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_ALLOC, 10'd0);
      send_request(ACT_RELEASE, 10'd900);
      send_request(ACT_RELEASE, 10'd2);
      send_request(ACT_ALLOC, 10'd0);

      // block limit below blocks already taken
      wait_idle();
      load_settings(1024, 30, 0, 1'b0);
      send_request(ACT_ALLOC, 10'd0);

      wait_idle();
      load_settings(8, 4096, 3, 1'b0);
      random_phase(PHASE_ITEMS);

      wait_idle();
      load_settings(1024, $urandom_range(1, 300), $urandom_range(0, 1023), 1'b0);
      random_phase(PHASE_ITEMS);

      wait_idle();
      load_settings($urandom_range(1, 40), 8191, $urandom_range(0, 40), 1'b0);
      random_phase(PHASE_ITEMS);

      wait_idle();
      load_settings(2047, 4096, 1023, 1'b0);
      random_phase(PHASE_ITEMS);

      wait_idle();
      load_settings(1, $urandom_range(4096, 8191), 0, 1'b0);
      random_phase(PHASE_ITEMS);

      wait_idle();
      load_settings($urandom_range(2, 64), 4096, $urandom_range(0, 64), 1'b0);
      calm <= 1'b1;
      random_phase(PHASE_ITEMS);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      drain = 0;
      while (beats_due != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (beats_due != 0) begin
         $display("%0d expected beats never arrived", beats_due);
      end
      if (mismatch_total == 0 && beats_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
